// ===== design/tlm_pkg.sv =====
package tlm_pkg;

    localparam logic [3:0] OP_START     = 4'd0;
    localparam logic [3:0] OP_STOP      = 4'd1;
    localparam logic [3:0] OP_WAKEUP    = 4'd2;
    localparam logic [3:0] OP_SWITCH_IN = 4'd3;
    localparam logic [3:0] OP_SWITCH_OUT = 4'd4;
    localparam logic [3:0] OP_TSLEEP    = 4'd5;
    localparam logic [3:0] OP_IRQ_ENTRY = 4'd6;
    localparam logic [3:0] OP_IRQ_EXIT  = 4'd7;
    localparam logic [3:0] OP_SET_BOUND = 4'd8;
    localparam logic [3:0] OP_READ      = 4'd9;

    localparam logic [1:0] MET_LATENCY  = 2'd0;
    localparam logic [1:0] MET_RESPONSE = 2'd1;
    localparam logic [1:0] MET_CYCLE    = 2'd2;
    localparam logic [1:0] MET_HANDLER  = 2'd3;

    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_TIMER = 2'd1;
    localparam logic [1:0] CAUSE_OTHER = 2'd2;

    localparam logic signed [63:0] SIGNED64_MAX = 64'sh7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic signed [63:0] min_v;
        logic signed [63:0] max_v;
        logic signed [63:0] bound;
        logic [31:0]        tally;
    } stat_t;

    typedef stat_t [3:0] stat_row_t;

    typedef struct packed {
        logic        active;
        logic [31:0] gen;
        logic [62:0] pending;
        logic [62:0] run_wake;
        logic [1:0]  next_cause;
        logic [1:0]  prev_cause;
        logic [62:0] cyc_start;
        logic        cyc_open;
        logic [62:0] irq_entry;
    } slot_t;

    typedef struct packed {
        logic               status;
        logic               measured;
        logic [1:0]         metric;
        logic signed [63:0] interval;
        logic               violated;
        logic signed [63:0] min_v;
        logic signed [63:0] max_v;
        logic [31:0]        vcount;
        logic [31:0]        gen;
        logic               last;
    } res_t;

endpackage

// ===== design/tlm_ram.sv =====
module tlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/tlm_stat_upd.sv =====
module tlm_stat_upd
    import tlm_pkg::*;
(
    input  logic               en,
    input  logic signed [63:0] iv,
    input  stat_t              st_in,
    output stat_t              st_out,
    output logic               vio
);

    always_comb
    begin
        st_out = st_in;
        vio    = 1'b0;
        if (en)
        begin
            if (iv > st_in.max_v)
            begin
                st_out.max_v = iv;
            end
            if (iv < st_in.min_v)
            begin
                st_out.min_v = iv;
            end
            if (iv > st_in.bound)
            begin
                st_out.tally = st_in.tally + 32'd1;
                vio          = 1'b1;
            end
        end
    end

endmodule

// ===== design/task_latency_monitor_unit.sv =====
// Results: after the event word is accepted, the first result word is valid once the
// slot memory read, interval subtract and stats update are done, later if results still wait.
// Events: a new event is taken only once the read-modify-write of the slot and
// stats memories for the last one is done. A second result drains while the next event is read.
// Reset: asynchronous, active low; it then runs a clearing pass over all TASK_SLOTS
// entries of both memories during which no event is accepted.
module task_latency_monitor_unit
    import tlm_pkg::*;
#(
    parameter int TASK_SLOTS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // task_id[15:0], timestamp[78:16], voluntary[79], metric_select[81:80],
    // bound_value[113:82], zero pad
    input  logic [119:0] s_axis_tdata,
    // opcode
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[0], measured[1], interval[65:2], violated[66], min_seen[130:67],
    // max_seen[194:131], violation_count[226:195], generation[258:227], zero pad
    output logic [263:0] m_axis_tdata,
    // metric
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [SW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [3:0]  op_reg;
    logic [15:0] id_reg;
    logic [62:0] now_reg;
    logic        vol_reg;
    logic [1:0]  sel_reg;
    logic [31:0] bnd_reg;

    logic signed [63:0] iv_a_reg, iv_b_reg;

    res_t        ob_reg [2];
    res_t        ob_next [2];
    logic [1:0]  ob_cnt_reg, ob_cnt_next;

    slot_t       slot_rd, slot_new;
    stat_row_t   stat_rd, stat_base, stat_new;
    logic [SW-1:0] slot_idx, waddr;
    logic        mem_we;
    slot_t       slot_wr;
    stat_row_t   stat_wr;

    logic        a_en, b_en, vio_a, vio_b, ignored, do_upd;
    logic [1:0]  a_met, fb_met, cause;
    stat_t       st_a, st_b;
    res_t        r0, r1;
    logic [1:0]  r_cnt;
    logic [62:0] from_a;

    assign slot_idx = id_reg[SW-1:0];

    tlm_ram #(.WIDTH($bits(slot_t)), .DEPTH(TASK_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (slot_wr),
        .raddr (slot_idx),
        .rdata (slot_rd)
    );

    tlm_ram #(.WIDTH($bits(stat_row_t)), .DEPTH(TASK_SLOTS)) u_stat_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (stat_wr),
        .raddr (slot_idx),
        .rdata (stat_rd)
    );

    tlm_stat_upd u_upd_a (
        .en     (a_en),
        .iv     (iv_a_reg),
        .st_in  (stat_base[a_met]),
        .st_out (st_a),
        .vio    (vio_a)
    );

    tlm_stat_upd u_upd_b (
        .en     (b_en),
        .iv     (iv_b_reg),
        .st_in  (stat_base[MET_CYCLE]),
        .st_out (st_b),
        .vio    (vio_b)
    );

    function automatic res_t mk_res(logic meas, logic [1:0] met, logic signed [63:0] iv,
                                    logic vio, stat_t st, logic [31:0] gen, logic lst);
        res_t r;
        r.status   = 1'b0;
        r.measured = meas;
        r.metric   = met;
        r.interval = meas ? iv : 64'sd0;
        r.violated = vio;
        r.min_v    = st.min_v;
        r.max_v    = st.max_v;
        r.vcount   = st.tally;
        r.gen      = gen;
        r.last     = lst;
        return r;
    endfunction

    // interval select, registered before the compares
    always_comb
    begin
        priority case (op_reg)
            OP_SWITCH_IN:  from_a = slot_rd.pending;
            OP_SWITCH_OUT: from_a = slot_rd.run_wake;
            default:       from_a = slot_rd.irq_entry;
        endcase
    end

    assign ignored = ({1'b0, id_reg} >= 17'(TASK_SLOTS)) || (op_reg > OP_READ) ||
                     ((op_reg != OP_START) && !slot_rd.active);

    always_comb
    begin
        slot_new  = slot_rd;
        stat_base = stat_rd;
        a_en      = 1'b0;
        b_en      = 1'b0;
        a_met     = MET_LATENCY;
        fb_met    = MET_LATENCY;
        cause     = slot_rd.next_cause;
        unique case (op_reg)
            OP_START:
            begin
                for (int m = 0; m < 4; m++)
                begin
                    stat_base[m].min_v = SIGNED64_MAX;
                    stat_base[m].max_v = 64'sd0;
                    stat_base[m].bound = SIGNED64_MAX;
                    stat_base[m].tally = 32'd0;
                end
                slot_new        = '0;
                slot_new.gen    = slot_rd.gen + 32'd1;
                slot_new.active = 1'b1;
            end
            OP_STOP:
            begin
                slot_new.active = 1'b0;
            end
            OP_WAKEUP:
            begin
                slot_new.pending = now_reg;
                if (slot_rd.prev_cause == CAUSE_TIMER)
                begin
                    slot_new.cyc_open  = 1'b1;
                    slot_new.cyc_start = now_reg;
                end
            end
            OP_SWITCH_IN:
            begin
                slot_new.pending = '0;
                if (slot_rd.pending != '0)
                begin
                    a_en              = 1'b1;
                    slot_new.run_wake = slot_rd.pending;
                end
            end
            OP_SWITCH_OUT:
            begin
                fb_met = MET_RESPONSE;
                a_met  = MET_RESPONSE;
                if (vol_reg)
                begin
                    if (cause == CAUSE_NONE)
                    begin
                        cause = CAUSE_OTHER;
                    end
                    slot_new.prev_cause = cause;
                    slot_new.next_cause = CAUSE_NONE;
                    slot_new.run_wake   = '0;
                    a_en = (slot_rd.run_wake != '0);
                    if ((cause == CAUSE_TIMER) && slot_rd.cyc_open)
                    begin
                        slot_new.cyc_start = '0;
                        slot_new.cyc_open  = 1'b0;
                        b_en = (slot_rd.cyc_start != '0);
                    end
                end
            end
            OP_TSLEEP:
            begin
                fb_met              = MET_CYCLE;
                slot_new.next_cause = CAUSE_TIMER;
            end
            OP_IRQ_ENTRY:
            begin
                fb_met             = MET_HANDLER;
                slot_new.irq_entry = now_reg;
            end
            OP_IRQ_EXIT:
            begin
                fb_met             = MET_HANDLER;
                a_met              = MET_HANDLER;
                slot_new.irq_entry = '0;
                a_en               = (slot_rd.irq_entry != '0);
            end
            OP_SET_BOUND:
            begin
                fb_met                  = sel_reg;
                stat_base[sel_reg].bound = 64'(signed'(bnd_reg));
            end
            default:
            begin
                fb_met = sel_reg;
            end
        endcase
    end

    always_comb
    begin
        stat_new = stat_base;
        if (a_en)
        begin
            stat_new[a_met] = st_a;
        end
        if (b_en)
        begin
            stat_new[MET_CYCLE] = st_b;
        end
    end

    always_comb
    begin
        r1    = '0;
        r_cnt = 2'd1;
        if (ignored)
        begin
            r0        = '0;
            r0.status = 1'b1;
            r0.last   = 1'b1;
        end
        else if (a_en && b_en)
        begin
            r0    = mk_res(1'b1, a_met, iv_a_reg, vio_a, stat_new[a_met], slot_new.gen, 1'b0);
            r1    = mk_res(1'b1, MET_CYCLE, iv_b_reg, vio_b, stat_new[MET_CYCLE],
                           slot_new.gen, 1'b1);
            r_cnt = 2'd2;
        end
        else if (a_en)
        begin
            r0 = mk_res(1'b1, a_met, iv_a_reg, vio_a, stat_new[a_met], slot_new.gen, 1'b1);
        end
        else if (b_en)
        begin
            r0 = mk_res(1'b1, MET_CYCLE, iv_b_reg, vio_b, stat_new[MET_CYCLE],
                        slot_new.gen, 1'b1);
        end
        else
        begin
            r0 = mk_res(1'b0, fb_met, 64'sd0, 1'b0, stat_new[fb_met], slot_new.gen, 1'b1);
        end
    end

    // hold the update until the output buffer has drained
    assign do_upd = (state_reg == S_UPD) && (ob_cnt_reg == 2'd0);

    always_comb
    begin
        mem_we  = 1'b0;
        waddr   = slot_idx;
        slot_wr = slot_new;
        stat_wr = stat_new;
        if (state_reg == S_CLR)
        begin
            mem_we  = 1'b1;
            waddr   = clr_cnt_reg;
            slot_wr = '0;
            stat_wr = '0;
        end
        else if (do_upd && !ignored)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SW'(TASK_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_CALC;
            S_CALC:  state_next = S_UPD;
            S_UPD:
            begin
                if (do_upd)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ob_next     = ob_reg;
        ob_cnt_next = ob_cnt_reg;
        if (do_upd)
        begin
            ob_next[0]  = r0;
            ob_next[1]  = r1;
            ob_cnt_next = r_cnt;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            ob_next[0]  = ob_reg[1];
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            ob_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ob_cnt_reg  <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg  <= s_axis_tuser;
            id_reg  <= s_axis_tdata[15:0];
            now_reg <= s_axis_tdata[78:16];
            vol_reg <= s_axis_tdata[79];
            sel_reg <= s_axis_tdata[81:80];
            bnd_reg <= s_axis_tdata[113:82];
        end
        if (state_reg == S_CALC)
        begin
            iv_a_reg <= {1'b0, now_reg} - {1'b0, from_a};
            iv_b_reg <= {1'b0, now_reg} - {1'b0, slot_rd.cyc_start};
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (ob_cnt_reg != 2'd0);
    assign m_axis_tdata  = {5'd0, ob_reg[0].gen, ob_reg[0].vcount, ob_reg[0].max_v,
                            ob_reg[0].min_v, ob_reg[0].violated, ob_reg[0].interval,
                            ob_reg[0].measured, ob_reg[0].status};
    assign m_axis_tuser  = ob_reg[0].metric;
    assign m_axis_tlast  = ob_reg[0].last;

    a_clr_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !s_axis_tready)
        else $error("event accepted during clearing pass");

    a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ob_cnt_reg <= 2'd2)
        else $error("output buffer overfilled");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_CLR) || (state_reg == S_UPD)))
        else $error("memory written outside clear or update");

    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_upd |=> (ob_cnt_reg != 2'd0))
        else $error("update produced no result");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import tlm_pkg::*;

    localparam int SLOTS = 256;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [3:0]  op;
        logic [15:0] id;
        logic [62:0] ts;
        logic        vol;
        logic [1:0]  sel;
        logic [31:0] bnd;
    } event_t;

    // expected result, plus a flag for rows whose value is typed in directly
    typedef struct {
        event_t ev;
        logic   fixed;
        res_t   want;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [263:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    task_latency_monitor_unit #(.TASK_SLOTS(SLOTS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // predictor copy of the slot and stats memories
    logic               act [SLOTS];
    logic [31:0]        gen_cnt [SLOTS];
    logic [63:0]        pend_wake [SLOTS];
    logic [63:0]        run_wake [SLOTS];
    logic [1:0]         next_cause [SLOTS];
    logic [1:0]         prev_cause [SLOTS];
    logic [63:0]        cyc_start [SLOTS];
    logic               cyc_open [SLOTS];
    logic [63:0]        irq_time [SLOTS];
    logic signed [63:0] st_min [SLOTS*4];
    logic signed [63:0] st_max [SLOTS*4];
    logic signed [63:0] st_bound [SLOTS*4];
    logic [31:0]        st_tally [SLOTS*4];

    res_t  pending_results[$];
    int    errors = 0;
    int    cycles = 0;
    int    n_results = 0;
    int    n_measured = 0;
    int    n_violated = 0;
    logic  quiet_out = 0;
    logic  [63:0] clock_ns = 64'd1000;

    initial clk = 0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic res_t stats_word(logic meas, logic [1:0] met, logic signed [63:0] iv,
                                        logic vio, int s);
        res_t r;
        int ix;
        ix = s*4 + met;
        r.status = 0;
        r.measured = meas;
        r.metric = met;
        r.interval = iv;
        r.violated = vio;
        r.min_v = st_min[ix];
        r.max_v = st_max[ix];
        r.vcount = st_tally[ix];
        r.gen = gen_cnt[s];
        r.last = 0;
        return r;
    endfunction

    function automatic res_t take_interval(int s, logic [1:0] met, logic [63:0] t_now,
                                           logic [63:0] t_from);
        logic signed [63:0] v;
        logic vio;
        int ix;
        ix = s*4 + met;
        v = $signed(t_now - t_from);
        vio = 0;
        if (v > st_max[ix]) st_max[ix] = v;
        if (v < st_min[ix]) st_min[ix] = v;
        if (v > st_bound[ix])
        begin
            st_tally[ix] = st_tally[ix] + 1;
            vio = 1;
        end
        return stats_word(1, met, v, vio, s);
    endfunction

    // advance the monitor model by one event and queue what it produces
    task automatic predict_event(event_t e);
        res_t out[$];
        res_t r;
        int s;
        logic [63:0] t_now;
        logic [63:0] wu;
        logic [1:0] cause;
        t_now = {1'b0, e.ts};
        if (e.id >= SLOTS || e.op > OP_READ || (e.op != OP_START && !act[e.id]))
        begin
            r = '0;
            r.status = 1;
            r.last = 1;
            pending_results.push_back(r);
            return;
        end
        s = e.id;
        case (e.op)
            OP_START:
            begin
                for (int m = 0; m < 4; m++)
                begin
                    st_min[s*4+m] = SIGNED64_MAX;
                    st_max[s*4+m] = 0;
                    st_bound[s*4+m] = SIGNED64_MAX;
                    st_tally[s*4+m] = 0;
                end
                pend_wake[s] = 0; run_wake[s] = 0;
                next_cause[s] = CAUSE_NONE; prev_cause[s] = CAUSE_NONE;
                cyc_start[s] = 0; cyc_open[s] = 0; irq_time[s] = 0;
                gen_cnt[s] = gen_cnt[s] + 1;
                act[s] = 1;
                out.push_back(stats_word(0, MET_LATENCY, 0, 0, s));
            end
            OP_STOP:
            begin
                act[s] = 0;
                out.push_back(stats_word(0, MET_LATENCY, 0, 0, s));
            end
            OP_WAKEUP:
            begin
                pend_wake[s] = t_now;
                if (prev_cause[s] == CAUSE_TIMER)
                begin
                    cyc_open[s] = 1;
                    cyc_start[s] = t_now;
                end
                out.push_back(stats_word(0, MET_LATENCY, 0, 0, s));
            end
            OP_SWITCH_IN:
            begin
                wu = pend_wake[s];
                pend_wake[s] = 0;
                if (wu != 0)
                begin
                    out.push_back(take_interval(s, MET_LATENCY, t_now, wu));
                    run_wake[s] = wu;
                end
                else
                    out.push_back(stats_word(0, MET_LATENCY, 0, 0, s));
            end
            OP_SWITCH_OUT:
            begin
                if (e.vol)
                begin
                    cause = next_cause[s];
                    wu = run_wake[s];
                    if (cause == CAUSE_NONE) cause = CAUSE_OTHER;
                    prev_cause[s] = cause;
                    next_cause[s] = CAUSE_NONE;
                    run_wake[s] = 0;
                    if (wu != 0)
                        out.push_back(take_interval(s, MET_RESPONSE, t_now, wu));
                    if (cause == CAUSE_TIMER && cyc_open[s])
                    begin
                        wu = cyc_start[s];
                        cyc_start[s] = 0;
                        if (wu != 0)
                            out.push_back(take_interval(s, MET_CYCLE, t_now, wu));
                        cyc_open[s] = 0;
                    end
                end
                if (out.size() == 0)
                    out.push_back(stats_word(0, MET_RESPONSE, 0, 0, s));
            end
            OP_TSLEEP:
            begin
                next_cause[s] = CAUSE_TIMER;
                out.push_back(stats_word(0, MET_CYCLE, 0, 0, s));
            end
            OP_IRQ_ENTRY:
            begin
                irq_time[s] = t_now;
                out.push_back(stats_word(0, MET_HANDLER, 0, 0, s));
            end
            OP_IRQ_EXIT:
            begin
                wu = irq_time[s];
                irq_time[s] = 0;
                if (wu != 0)
                    out.push_back(take_interval(s, MET_HANDLER, t_now, wu));
                else
                    out.push_back(stats_word(0, MET_HANDLER, 0, 0, s));
            end
            OP_SET_BOUND:
            begin
                st_bound[s*4+e.sel] = {{32{e.bnd[31]}}, e.bnd};
                out.push_back(stats_word(0, e.sel, 0, 0, s));
            end
            default:
                out.push_back(stats_word(0, e.sel, 0, 0, s));
        endcase
        out[out.size()-1].last = 1;
        foreach (out[i]) pending_results.push_back(out[i]);
    endtask

    // drive one event word, with a random idle gap in front when gaps is set; valid stays up
    // after the accept until the next word or an explicit idle replaces it
    task automatic send_event(event_t e, logic gaps);
        if (gaps)
            while ($urandom_range(99) < 38)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1;
        s_axis_tuser <= e.op;
        s_axis_tdata <= {6'd0, e.bnd, e.sel, e.vol, e.ts, e.id};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    function automatic event_t mk(logic [3:0] op, logic [15:0] id, logic [62:0] ts,
                                  logic vol, logic [1:0] sel, logic [31:0] bnd);
        event_t e;
        e.op = op; e.id = id; e.ts = ts; e.vol = vol; e.sel = sel; e.bnd = bnd;
        return e;
    endfunction

    function automatic event_t rand_event(logic [15:0] id);
        logic [3:0] op;
        logic [62:0] ts;
        op = 4'($urandom_range(9));
        clock_ns = clock_ns + 64'($urandom_range(1, 5000));
        // mostly rising timestamps, some out of order or extreme
        case ($urandom_range(19))
            0: ts = 63'({$urandom, $urandom});
            1: ts = 0;
            2: ts = clock_ns[62:0] - 63'($urandom_range(20000));
            default: ts = clock_ns[62:0];
        endcase
        return mk(op, id, ts, $urandom_range(3) != 0, 2'($urandom_range(3)),
                  $urandom_range(7) == 0 ? $urandom : $urandom_range(6000));
    endfunction

    // receiver: stall at random unless quiet_out is set, compare each word against the oldest prediction
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status   = m_axis_tdata[0];
                got.measured = m_axis_tdata[1];
                got.interval = m_axis_tdata[65:2];
                got.violated = m_axis_tdata[66];
                got.min_v    = m_axis_tdata[130:67];
                got.max_v    = m_axis_tdata[194:131];
                got.vcount   = m_axis_tdata[226:195];
                got.gen      = m_axis_tdata[258:227];
                got.metric   = m_axis_tuser;
                got.last     = m_axis_tlast;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_results++;
                    if (got.measured) n_measured++;
                    if (got.violated) n_violated++;
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        $display("  st %b/%b ms %b/%b met %0d/%0d iv %0d/%0d vio %b/%b",
                                 want.status, got.status, want.measured, got.measured,
                                 want.metric, got.metric, want.interval, got.interval,
                                 want.violated, got.violated);
                        $display("  min %0d/%0d max %0d/%0d cnt %0d/%0d gen %0d/%0d last %b/%b",
                                 want.min_v, got.min_v, want.max_v, got.max_v,
                                 want.vcount, got.vcount, want.gen, got.gen,
                                 want.last, got.last);
                    end
                end
            end
            m_axis_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 38);
        end
    end

    row_t dir[$];
    row_t rw;
    res_t ign;
    logic [15:0] pool [8];

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_START;
        m_axis_tready = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            act[i] = 0; gen_cnt[i] = 0; pend_wake[i] = 0; run_wake[i] = 0;
            next_cause[i] = 0; prev_cause[i] = 0; cyc_start[i] = 0; cyc_open[i] = 0;
            irq_time[i] = 0;
        end
        for (int i = 0; i < SLOTS*4; i++)
        begin
            st_min[i] = 0; st_max[i] = 0; st_bound[i] = 0; st_tally[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1;

        ign = '0;
        ign.status = 1;
        ign.last = 1;
        // directed table: ignored events carry typed-in results
        dir = '{
            '{mk(OP_READ, 16'd5, 63'd1, 0, MET_HANDLER, 0), 1, ign},
            '{mk(OP_START, 16'hFFFF, 63'd1, 0, 0, 0), 1, ign},
            '{mk(4'd15, 16'd5, '1, 1, 3, '1), 1, ign},
            '{mk(4'd10, 16'd5, 63'd7, 0, 0, 0), 1, ign},
            '{mk(OP_START, 16'd5, 63'd0, 0, 0, 0), 0, ign},
            '{mk(OP_START, 16'd255, 63'd0, 0, 0, 0), 0, ign},
            '{mk(OP_START, 16'd256, 63'd0, 0, 0, 0), 1, ign},
            '{mk(OP_SET_BOUND, 16'd5, 0, 0, MET_LATENCY, 32'd100), 0, ign},
            '{mk(OP_SET_BOUND, 16'd5, 0, 0, MET_RESPONSE, 32'h8000_0000), 0, ign},
            '{mk(OP_SET_BOUND, 16'd5, 0, 0, MET_HANDLER, 32'h7FFF_FFFF), 0, ign},
            '{mk(OP_SWITCH_IN, 16'd5, 63'd50, 0, 0, 0), 0, ign},
            '{mk(OP_WAKEUP, 16'd5, 63'd1000, 0, 0, 0), 0, ign},
            '{mk(OP_SWITCH_IN, 16'd5, 63'd1500, 0, 0, 0), 0, ign},
            '{mk(OP_TSLEEP, 16'd5, 63'd1600, 0, 0, 0), 0, ign},
            '{mk(OP_SWITCH_OUT, 16'd5, 63'd1700, 1, 0, 0), 0, ign},
            '{mk(OP_WAKEUP, 16'd5, 63'd2000, 0, 0, 0), 0, ign},
            '{mk(OP_SWITCH_IN, 16'd5, 63'd1990, 0, 0, 0), 0, ign},
            '{mk(OP_TSLEEP, 16'd5, 63'd2100, 0, 0, 0), 0, ign},
            '{mk(OP_SWITCH_OUT, 16'd5, 63'd2500, 1, 0, 0), 0, ign},
            '{mk(OP_SWITCH_OUT, 16'd5, 63'd2600, 0, 0, 0), 0, ign},
            '{mk(OP_IRQ_EXIT, 16'd5, 63'd2700, 0, 0, 0), 0, ign},
            '{mk(OP_IRQ_ENTRY, 16'd5, '1, 0, 0, 0), 0, ign},
            '{mk(OP_IRQ_EXIT, 16'd5, 63'd3, 0, 0, 0), 0, ign},
            '{mk(OP_READ, 16'd5, 0, 0, MET_CYCLE, 0), 0, ign},
            '{mk(OP_STOP, 16'd5, 0, 0, 0, 0), 0, ign}
        };
        foreach (dir[i])
        begin
            rw = dir[i];
            if (rw.fixed)
                pending_results.push_back(rw.want);
            else
                predict_event(rw.ev);
            send_event(rw.ev, 1);
        end

        // random part: a small pool of slots, kept mostly active
        for (int i = 0; i < 8; i++) pool[i] = 16'($urandom_range(SLOTS - 1));
        pool[0] = 16'd0;
        pool[1] = 16'(SLOTS - 1);
        for (int k = 0; k < 900; k++)
        begin
            event_t e;
            logic [15:0] id;
            quiet_out = (k >= 300 && k < 400);
            if (k == 450)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            id = $urandom_range(29) == 0 ? 16'($urandom) : pool[$urandom_range(7)];
            e = rand_event(id);
            if (id < SLOTS && !act[id] && $urandom_range(3) != 0) e.op = OP_START;
            if (e.op == OP_STOP && $urandom_range(2) != 0) e.op = OP_READ;
            predict_event(e);
            send_event(e, !(k >= 300 && k < 400));
        end
        s_axis_tvalid <= 0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d result words, %0d measured intervals, %0d over bound",
                 n_results, n_measured, n_violated);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
